// ===== rtl/polyca_pkg.sv =====
package polyca_pkg;

    // accumulator and result widths
    localparam int CROSS_W     = 43;
    localparam int MOMENT_W    = 59;
    localparam int AREA_W      = 41;
    localparam int CENT_W      = 32;
    localparam int OUT_TDATA_W = ((AREA_W + 2 * CENT_W + 7) / 8) * 8;

    // divider step counter
    localparam int DCNT_W = $clog2(MOMENT_W);

    // halved area saturation bounds, held at the cross sum width
    localparam logic signed [CROSS_W-1:0] AREA_MAX =
        CROSS_W'((64'sd1 <<< (AREA_W - 1)) - 64'sd1);
    localparam logic signed [CROSS_W-1:0] AREA_MIN =
        CROSS_W'(-(64'sd1 <<< (AREA_W - 1)));

    // centroid magnitude limits for the positive and negative side
    localparam logic [MOMENT_W-1:0] CENT_POS_LIM =
        MOMENT_W'((64'd1 << (CENT_W - 1)) - 64'd1);
    localparam logic [MOMENT_W-1:0] CENT_NEG_LIM =
        MOMENT_W'(64'd1 << (CENT_W - 1));
    localparam logic [CENT_W-1:0] CENT_MAX = {1'b0, {(CENT_W - 1){1'b1}}};
    localparam logic [CENT_W-1:0] CENT_MIN = {1'b1, {(CENT_W - 1){1'b0}}};

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_M1   = 10'b00_0000_0010,
        ST_M2   = 10'b00_0000_0100,
        ST_M3   = 10'b00_0000_1000,
        ST_M4   = 10'b00_0001_0000,
        ST_HALF = 10'b00_0010_0000,
        ST_DSET = 10'b00_0100_0000,
        ST_DIV  = 10'b00_1000_0000,
        ST_SAT  = 10'b01_0000_0000,
        ST_OUT  = 10'b10_0000_0000
    } state_t;

endpackage

// ===== rtl/polygon_centroid_area_unit.sv =====
// shoelace area and centroid of a polygon streamed in vertex by vertex
//
// input channel s_axis: one transfer per vertex, x and y in tdata, tlast set on
// the final vertex of the polygon. output channel m_axis: one transfer per
// polygon, carrying the halved signed area, the centroid and a degenerate flag.
//
// sequence: the first vertex of a polygon is only accepted; each later vertex is
// accepted and then makes four passes through the one shared signed multiplier (two cross
// terms, then the x and y moments). the final vertex also runs the closing edge
// back to the first vertex, then the halving step and two 59-step restoring
// divisions on a shared compare/subtract unit, one quotient bit per cycle.
// degenerate polygons skip the divisions, and a lone point also skips the edge passes.
//
// the block holds s_axis_tready low while it works on a vertex. a finished
// result sits in the output register; the next polygon may stream in while it
// waits, and only the next final vertex stalls until m_axis takes the result.
// reset clears the sequencer, the first-vertex flag and all sums; the block is
// ready for a new polygon in the first cycle after reset.
module polygon_centroid_area_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // vertex input
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  logic [((2 * COORD_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // vertex_x, vertex_y
    input  logic                                      s_axis_tlast,  // last_vertex
    // result output
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    output logic [polyca_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,  // area, centroid_x, centroid_y
    output logic                                      m_axis_tuser   // degenerate
);
    import polyca_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int AW = CW + 1;        // multiplier a side: coordinate or coordinate sum
    localparam int BW = 2 * CW + 1;    // multiplier b side: coordinate or cross term
    localparam int PW = AW + BW;

    // field positions in the output word
    localparam int CX_LO = AREA_W;
    localparam int CY_LO = AREA_W + CENT_W;
    localparam int PAD_W = OUT_TDATA_W - AREA_W - 2 * CENT_W;

    state_t state_reg, state_next;

    // vertex bookkeeping
    logic                    have_first_reg;
    logic                    last_reg;      // polygon ends with the current vertex
    logic                    close_reg;     // closing edge still to run
    logic signed [CW-1:0]    first_x_reg, first_y_reg;
    logic signed [CW-1:0]    prev_x_reg, prev_y_reg;

    // edge operands (a to b)
    logic signed [CW-1:0]    ax_reg, ay_reg, bx_reg, by_reg;

    // shared multiplier
    logic signed [AW-1:0]    mul_a;
    logic signed [BW-1:0]    mul_b;
    logic signed [PW-1:0]    mul_p;
    logic signed [BW-1:0]    prod_reg;
    logic signed [BW-1:0]    c_reg;

    // sums
    logic signed [CROSS_W-1:0]  cross_reg;
    logic signed [MOMENT_W-1:0] mx_reg, my_reg;

    // closing arithmetic
    logic signed [CROSS_W-1:0]  half_reg;
    logic signed [CROSS_W-1:0]  cs_adj;
    logic signed [CROSS_W-1:0]  half_calc;
    logic signed [MOMENT_W-1:0] half_ext, six_half, div_src;
    logic [MOMENT_W-1:0]        dvs_mag, dvd_mag;

    // shared divider
    logic                    sel_y_reg;
    logic                    neg_reg;
    logic [DCNT_W-1:0]       div_cnt_reg;
    logic [MOMENT_W-1:0]     dvs_reg, rem_reg, quo_reg;
    logic [MOMENT_W:0]       div_sh, div_diff;
    logic                    div_bit;
    logic [CENT_W-1:0]       cent_sat;
    logic [CENT_W-1:0]       cx_reg, cy_reg;

    // output register
    logic                    m_valid_reg;
    logic [OUT_TDATA_W-1:0]  m_data_reg;
    logic                    m_degen_reg;
    logic signed [CROSS_W-1:0] area_sat;

    logic s_fire;
    logic out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_degen_reg;

    // multiplier operand select: ax*by, bx*ay, (ax+bx)*c, (ay+by)*c
    always_comb
    begin
        unique case (state_reg)
            ST_M1:
            begin
                mul_a = AW'(ax_reg);
                mul_b = BW'(by_reg);
            end
            ST_M2:
            begin
                mul_a = AW'(bx_reg);
                mul_b = BW'(ay_reg);
            end
            ST_M3:
            begin
                mul_a = AW'(ax_reg) + AW'(bx_reg);
                mul_b = c_reg;
            end
            ST_M4:
            begin
                mul_a = AW'(ay_reg) + AW'(by_reg);
                mul_b = c_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // halving with truncation toward zero
    always_comb
    begin
        cs_adj    = cross_reg + $signed({{(CROSS_W - 1){1'b0}}, cross_reg[CROSS_W-1]});
        half_calc = cs_adj >>> 1;
    end

    // divisor 6*half as shift-add, and dividend magnitude
    always_comb
    begin
        half_ext = MOMENT_W'(half_reg);
        six_half = (half_ext <<< 2) + (half_ext <<< 1);
        dvs_mag  = six_half[MOMENT_W-1] ? MOMENT_W'(-six_half) : MOMENT_W'(six_half);
        div_src  = sel_y_reg ? my_reg : mx_reg;
        dvd_mag  = div_src[MOMENT_W-1] ? MOMENT_W'(-div_src) : MOMENT_W'(div_src);
    end

    // one restoring division step
    always_comb
    begin
        div_sh   = {rem_reg, quo_reg[MOMENT_W-1]};
        div_diff = div_sh - {1'b0, dvs_reg};
        div_bit  = !div_diff[MOMENT_W];
    end

    // quotient sign and 32-bit saturation
    always_comb
    begin
        if (!neg_reg)
        begin
            cent_sat = (quo_reg > CENT_POS_LIM) ? CENT_MAX : quo_reg[CENT_W-1:0];
        end
        else
        begin
            cent_sat = (quo_reg > CENT_NEG_LIM) ? CENT_MIN : CENT_W'(-quo_reg[CENT_W-1:0]);
        end
    end

    // halved area saturation
    always_comb
    begin
        if (half_reg > AREA_MAX)
        begin
            area_sat = AREA_MAX;
        end
        else if (half_reg < AREA_MIN)
        begin
            area_sat = AREA_MIN;
        end
        else
        begin
            area_sat = half_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (have_first_reg)
                    begin
                        state_next = ST_M1;
                    end
                    else if (s_axis_tlast)
                    begin
                        // single point, the closing edge adds nothing
                        state_next = ST_HALF;
                    end
                end
            end
            ST_M1:   state_next = ST_M2;
            ST_M2:   state_next = ST_M3;
            ST_M3:   state_next = ST_M4;
            ST_M4:
            begin
                if (close_reg)
                begin
                    state_next = ST_M1;
                end
                else if (last_reg)
                begin
                    state_next = ST_HALF;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_HALF: state_next = ST_DSET;
            ST_DSET:
            begin
                if (half_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == DCNT_W'(MOMENT_W - 1))
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:  state_next = sel_y_reg ? ST_OUT : ST_DSET;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            have_first_reg <= 1'b0;
            last_reg       <= 1'b0;
            close_reg      <= 1'b0;
            sel_y_reg      <= 1'b0;
            div_cnt_reg    <= '0;
            cross_reg      <= '0;
            mx_reg         <= '0;
            my_reg         <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // output valid: set when a result is loaded, cleared once taken
            if (state_reg == ST_OUT && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        have_first_reg <= 1'b1;
                        last_reg       <= s_axis_tlast;
                        close_reg      <= s_axis_tlast && have_first_reg;
                    end
                end
                ST_M3:
                begin
                    cross_reg <= cross_reg + CROSS_W'(c_reg);
                    mx_reg    <= mx_reg + MOMENT_W'(mul_p);
                end
                ST_M4:
                begin
                    my_reg    <= my_reg + MOMENT_W'(mul_p);
                    close_reg <= 1'b0;
                end
                ST_DSET:
                begin
                    div_cnt_reg <= '0;
                end
                ST_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
                ST_SAT:
                begin
                    sel_y_reg <= 1'b1;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        have_first_reg <= 1'b0;
                        last_reg       <= 1'b0;
                        sel_y_reg      <= 1'b0;
                        cross_reg      <= '0;
                        mx_reg         <= '0;
                        my_reg         <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    prev_x_reg <= s_axis_tdata[CW-1:0];
                    prev_y_reg <= s_axis_tdata[2*CW-1:CW];
                    ax_reg     <= prev_x_reg;
                    ay_reg     <= prev_y_reg;
                    bx_reg     <= s_axis_tdata[CW-1:0];
                    by_reg     <= s_axis_tdata[2*CW-1:CW];
                    if (!have_first_reg)
                    begin
                        first_x_reg <= s_axis_tdata[CW-1:0];
                        first_y_reg <= s_axis_tdata[2*CW-1:CW];
                    end
                end
            end
            ST_M1:
            begin
                prod_reg <= BW'(mul_p);
            end
            ST_M2:
            begin
                c_reg <= prod_reg - BW'(mul_p);
            end
            ST_M4:
            begin
                // closing edge runs from the last vertex back to the first
                if (close_reg)
                begin
                    ax_reg <= bx_reg;
                    ay_reg <= by_reg;
                    bx_reg <= first_x_reg;
                    by_reg <= first_y_reg;
                end
            end
            ST_HALF:
            begin
                half_reg <= half_calc;
            end
            ST_DSET:
            begin
                if (half_reg == '0)
                begin
                    cx_reg <= '0;
                    cy_reg <= '0;
                end
                dvs_reg <= dvs_mag;
                quo_reg <= dvd_mag;
                rem_reg <= '0;
                neg_reg <= div_src[MOMENT_W-1] ^ half_reg[CROSS_W-1];
            end
            ST_DIV:
            begin
                rem_reg <= div_bit ? div_diff[MOMENT_W-1:0] : div_sh[MOMENT_W-1:0];
                quo_reg <= {quo_reg[MOMENT_W-2:0], div_bit};
            end
            ST_SAT:
            begin
                if (sel_y_reg)
                begin
                    cy_reg <= cent_sat;
                end
                else
                begin
                    cx_reg <= cent_sat;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_data_reg  <= {{PAD_W{1'b0}}, cy_reg, cx_reg, area_sat[AREA_W-1:0]};
                    m_degen_reg <= (half_reg == '0);
                end
            end
            default:
            begin
            end
        endcase
    end

    // a result only appears out of the output state
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output state");

    // degenerate results carry a zero centroid
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_degen_reg |->
            m_data_reg[CX_LO+CENT_W-1:CX_LO] == '0 && m_data_reg[CY_LO+CENT_W-1:CY_LO] == '0)
        else $error("degenerate result with nonzero centroid");

    // edges are only formed once a first vertex is held
    a_edge_first: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_M1 |-> have_first_reg)
        else $error("edge started with no first vertex");

    // the final vertex always starts closing work
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && s_axis_tlast |=> state_reg != ST_IDLE)
        else $error("final vertex did not start the closing sequence");

    // divider step count stays within the dividend width
    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> div_cnt_reg < DCNT_W'(MOMENT_W))
        else $error("divider step count out of range");

endmodule

// ===== test/polygon_centroid_checker.sv =====
module polygon_centroid_checker
    import polyca_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [31:0]            s_data,   // vertex_x, vertex_y
    input  logic                   s_last,   // last_vertex
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [OUT_TDATA_W-1:0] m_data,   // area, centroid_x, centroid_y
    input  logic                   m_user,   // degenerate
    output int                     fail_count,
    output int                     pending,
    output int                     results_checked,
    output int                     degenerate_seen
);

    localparam int MAX_REPORTS = 40;

    typedef struct {
        logic signed [AREA_W-1:0] area;
        logic signed [CENT_W-1:0] cent_x;
        logic signed [CENT_W-1:0] cent_y;
        logic                     degen;
    } centroid_result_t;

    // running polygon state
    logic signed [15:0]         first_x, first_y, prev_x, prev_y;
    logic                       seen_first;
    logic signed [CROSS_W-1:0]  cross_acc;
    logic signed [MOMENT_W-1:0] mom_x_acc, mom_y_acc;

    centroid_result_t polygon_results_q[$];
    centroid_result_t got, want, fresh;
    int               mism;
    int               reports;

    function automatic void clear_polygon();
        first_x    = '0;
        first_y    = '0;
        prev_x     = '0;
        prev_y     = '0;
        seen_first = 1'b0;
        cross_acc  = '0;
        mom_x_acc  = '0;
        mom_y_acc  = '0;
    endfunction

    // sums wrap at their own widths
    function automatic void accumulate_edge(input longint ax, input longint ay,
                                            input longint bx, input longint by);
        longint c;
        c         = ax * by - bx * ay;
        cross_acc = CROSS_W'(cross_acc + c);
        mom_x_acc = MOMENT_W'(mom_x_acc + (ax + bx) * c);
        mom_y_acc = MOMENT_W'(mom_y_acc + (ay + by) * c);
    endfunction

    function automatic longint clamp(input longint v, input int bits);
        longint hi, lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic bit take_vertex(input logic signed [15:0] vx,
                                       input logic signed [15:0] vy,
                                       input logic closing,
                                       output centroid_result_t res);
        longint cs, half, divisor;
        res.area   = '0;
        res.cent_x = '0;
        res.cent_y = '0;
        res.degen  = 1'b0;
        if (seen_first)
            accumulate_edge(prev_x, prev_y, vx, vy);
        else
        begin
            first_x    = vx;
            first_y    = vy;
            seen_first = 1'b1;
        end
        prev_x = vx;
        prev_y = vy;
        if (!closing)
            return 1'b0;
        accumulate_edge(vx, vy, first_x, first_y);
        cs        = longint'(cross_acc);
        half      = cs / 2;
        res.degen = (cs == 0) || (half == 0);
        res.area  = AREA_W'(clamp(half, AREA_W));
        if (!res.degen)
        begin
            // divide by the unclamped halved area
            divisor    = 6 * half;
            res.cent_x = CENT_W'(clamp(longint'(mom_x_acc) / divisor, CENT_W));
            res.cent_y = CENT_W'(clamp(longint'(mom_y_acc) / divisor, CENT_W));
        end
        clear_polygon();
        return 1'b1;
    endfunction

    function automatic int field_mismatch(input string name, input longint exp_v,
                                          input longint act_v);
        if (exp_v == act_v)
            return 0;
        if (reports < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        reports++;
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_polygon();
            polygon_results_q.delete();
            reports         = 0;
            fail_count      <= 0;
            pending         <= 0;
            results_checked <= 0;
            degenerate_seen <= 0;
        end
        else
        begin
            if (m_valid && m_ready)
            begin
                got.area   = m_data[AREA_W-1:0];
                got.cent_x = m_data[AREA_W +: CENT_W];
                got.cent_y = m_data[AREA_W + CENT_W +: CENT_W];
                got.degen  = m_user;
                if (polygon_results_q.size() == 0)
                begin
                    if (reports < MAX_REPORTS)
                        $display("%0t: result transfer with no polygon outstanding, area %0d",
                                 $time, got.area);
                    reports++;
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = polygon_results_q.pop_front();
                    mism = field_mismatch("area", want.area, got.area)
                         + field_mismatch("centroid_x", want.cent_x, got.cent_x)
                         + field_mismatch("centroid_y", want.cent_y, got.cent_y)
                         + field_mismatch("degenerate", want.degen, got.degen);
                    if (mism != 0)
                        fail_count <= fail_count + 1;
                    results_checked <= results_checked + 1;
                    if (want.degen)
                        degenerate_seen <= degenerate_seen + 1;
                end
            end
            if (s_valid && s_ready)
            begin
                if (take_vertex($signed(s_data[15:0]), $signed(s_data[31:16]), s_last, fresh))
                    polygon_results_q.insert(polygon_results_q.size(), fresh);
            end
            pending <= polygon_results_q.size();
        end
    end

endmodule

// ===== test/tb_polygon_centroid_area_unit.sv =====
module tb_polygon_centroid_area_unit;

    import polyca_pkg::*;

    // run shape
    localparam int RANDOM_ITEMS   = 680;   // vertices in the random part
    localparam int QUIET_TAIL     = 150;   // last random vertices sent with no idling
    localparam int HOLD_AFTER     = 200;   // random vertices before the long output stall
    localparam int RX_HOLD_CYCLES = 800;   // length of the long output stall
    localparam int DRAIN_CYCLES   = 200;   // idle time after the last result, watching for stray transfers
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transfer on either channel

    logic                   clk;
    logic                   rst_n   = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [31:0]            s_data  = '0;    // vertex_x, vertex_y
    logic                   s_last  = 1'b0;  // last_vertex
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_data;          // area, centroid_x, centroid_y
    logic                   m_user;          // degenerate

    // idling control shared by both sides
    logic idle_on   = 1'b0;
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;

    int fail_count, pending, results_checked, degenerate_seen;
    int vertices_sent = 0;
    int polygons_sent = 0;
    int stall_cycles  = 0;

    // vertices of the polygon about to be sent, y in the upper half
    logic [31:0] poly_q[$];

    polygon_centroid_area_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_valid),
        .s_axis_tready(s_ready),
        .s_axis_tdata (s_data),
        .s_axis_tlast (s_last),
        .m_axis_tvalid(m_valid),
        .m_axis_tready(m_ready),
        .m_axis_tdata (m_data),
        .m_axis_tuser (m_user)
    );

    // predicts every polygon result and compares the output transfers
    polygon_centroid_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .m_user         (m_user),
        .fail_count     (fail_count),
        .pending        (pending),
        .results_checked(results_checked),
        .degenerate_seen(degenerate_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: ends the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
                $display("FAIL polygon_centroid_area_unit");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // result side: random stall bursts, plus one long hold-off so that the
    // output register stays full and the next final vertex backs up the input
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else
                m_ready <= 1'b1;
        end
    end

    function automatic logic [31:0] vtx(input int x, input int y);
        return {16'(y), 16'(x)};
    endfunction

    // one vertex transfer, sometimes after a short idle burst
    task automatic send_vertex(input logic [31:0] v, input logic closing);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= v;
        s_last  <= closing;
        do
            @(posedge clk);
        while (!s_ready);
        @(negedge clk);
        vertices_sent++;
    endtask

    task automatic send_polygon();
        for (int i = 0; i < poly_q.size(); i++)
            send_vertex(poly_q[i], i == poly_q.size() - 1);
        polygons_sent++;
    endtask

    // extreme square wound many times: far past the vertex limit, the area
    // saturates and with enough turns the cross sum wraps
    task automatic send_winding_square(input int turns);
        poly_q.delete();
        for (int t = 0; t < turns; t++)
        begin
            poly_q.insert(poly_q.size(), vtx(-32768, -32768));
            poly_q.insert(poly_q.size(), vtx(32767, -32768));
            poly_q.insert(poly_q.size(), vtx(32767, 32767));
            poly_q.insert(poly_q.size(), vtx(-32768, 32767));
        end
        send_polygon();
    endtask

    initial
    begin : stimulus
        int random_base, kind, n, w, h, d;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idle_on <= 1'b1;

        // directed part
        // a lone marked vertex is a point polygon
        poly_q = '{vtx(32767, -32768)};
        send_polygon();
        // cross sum of one halves to zero area
        poly_q = '{vtx(0, 0), vtx(1, 0), vtx(0, 1)};
        send_polygon();
        // clockwise, cross sum of minus three truncates toward zero
        poly_q = '{vtx(0, 0), vtx(0, 1), vtx(3, 0)};
        send_polygon();
        // full-range square
        poly_q = '{vtx(-32768, -32768), vtx(32767, -32768), vtx(32767, 32767),
                   vtx(-32768, 32767)};
        send_polygon();
        // segment
        poly_q = '{vtx(-32768, 32767), vtx(32767, -32768)};
        send_polygon();
        // bowtie with almost cancelling lobes: centroid saturates
        poly_q = '{vtx(-32768, -32768), vtx(32767, 32767), vtx(32767, -32768),
                   vtx(-32768, 32766)};
        send_polygon();
        // collinear points
        poly_q = '{vtx(5, 5), vtx(10, 10), vtx(-20, -20)};
        send_polygon();

        // beyond the vertex limit: the halved area saturates
        send_winding_square(275);

        // random part, mostly ordinary polygons with random content
        random_base = vertices_sent;
        while (vertices_sent - random_base < RANDOM_ITEMS)
        begin
            if (vertices_sent - random_base >= RANDOM_ITEMS - QUIET_TAIL)
                idle_on <= 1'b0;
            else
                idle_on <= ($urandom_range(0, 4) != 0);
            if (vertices_sent - random_base >= HOLD_AFTER)
                hold_req <= 1'b1;

            kind = $urandom_range(0, 9);
            poly_q.delete();
            if (kind <= 5)
            begin
                n = $urandom_range(3, 10);
                repeat (n) poly_q.insert(poly_q.size(), $urandom());
            end
            else if (kind == 6)
            begin
                // tiny coordinates: frequent zero and near-zero areas
                n = $urandom_range(3, 8);
                repeat (n) poly_q.insert(poly_q.size(), vtx($urandom_range(0, 7) - 4,
                                                            $urandom_range(0, 7) - 4));
            end
            else if (kind == 7)
            begin
                w = $urandom_range(16384, 32767);
                h = $urandom_range(16384, 32760);
                d = $urandom_range(0, 3);
                poly_q = '{vtx(-w, -h), vtx(w, h), vtx(w, -h), vtx(-w, h + d)};
            end
            else if (kind == 8)
            begin
                n = $urandom_range(1, 2);
                repeat (n) poly_q.insert(poly_q.size(), $urandom());
            end
            else
            begin
                n = $urandom_range(11, 40);
                repeat (n) poly_q.insert(poly_q.size(), $urandom());
            end
            send_polygon();
        end

        s_valid <= 1'b0;
        s_last  <= 1'b0;

        // wait for every polygon result, then watch for stray transfers
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("sent %0d vertices in %0d polygons, including a winding square past the limit",
                 vertices_sent, polygons_sent);
        $display("checked %0d results (%0d degenerate), %0d failing, long output stall %0s",
                 results_checked, degenerate_seen, fail_count, hold_done ? "done" : "missed");
        if (fail_count == 0 && pending == 0)
            $display("PASS polygon_centroid_area_unit");
        else
            $display("FAIL polygon_centroid_area_unit");
        $finish;
    end

endmodule
